/* design/mlbd_pkg.sv */
// Shared constants, types and the channel averaging function of the mip box downsampler.
package mlbd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE = 2'd2;

  // Clamped sizes and position counters.
  localparam int DIMW_W = $clog2(MAX_WIDTH + 1);
  localparam int DIMH_W = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  // The row store is split into an even-column bank and an odd-column bank.
  localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam int PIX_W = 16;

  // Pixel formats.
  localparam logic MODE_RGB565   = 1'b0;
  localparam logic MODE_ARGB4444 = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // Item between the position stage and the averaging stage.
  typedef struct packed {
    logic two_d;
    logic last;
    pix_t held;
    pix_t px;
  } mlbd_s1_t;

  function automatic logic [5:0] mean4(logic [5:0] a, logic [5:0] b,
                                       logic [5:0] c, logic [5:0] d);
    logic [7:0] s;
    s = 8'(a) + 8'(b) + 8'(c) + 8'(d);
    return s[7:2];
  endfunction

  // Floor of the per-channel mean of four pixels.
  function automatic pix_t avg4(pix_t a, pix_t b, pix_t c, pix_t d, logic mode);
    logic [5:0] t0;
    logic [5:0] t1;
    logic [5:0] t2;
    logic [5:0] t3;
    pix_t       r;
    if (mode == MODE_ARGB4444) begin
      t0 = mean4({2'b0, a[15:12]}, {2'b0, b[15:12]}, {2'b0, c[15:12]}, {2'b0, d[15:12]});
      t1 = mean4({2'b0, a[11:8]}, {2'b0, b[11:8]}, {2'b0, c[11:8]}, {2'b0, d[11:8]});
      t2 = mean4({2'b0, a[7:4]}, {2'b0, b[7:4]}, {2'b0, c[7:4]}, {2'b0, d[7:4]});
      t3 = mean4({2'b0, a[3:0]}, {2'b0, b[3:0]}, {2'b0, c[3:0]}, {2'b0, d[3:0]});
      r  = {t0[3:0], t1[3:0], t2[3:0], t3[3:0]};
    end else begin
      t0 = mean4({1'b0, a[15:11]}, {1'b0, b[15:11]}, {1'b0, c[15:11]}, {1'b0, d[15:11]});
      t1 = mean4(a[10:5], b[10:5], c[10:5], d[10:5]);
      t2 = mean4({1'b0, a[4:0]}, {1'b0, b[4:0]}, {1'b0, c[4:0]}, {1'b0, d[4:0]});
      t3 = 6'd0;
      r  = {t0[4:0], t1[5:0], t2[4:0] | t3[4:0]};
    end
    return r;
  endfunction

endpackage

/* design/mlbd_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module mlbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/mlbd_ctrl.sv */
// Configuration registers, position counters, held pixel and row store control.
module mlbd_ctrl import mlbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  cfg_ready,
  input  logic                  in_xfer,
  input  pix_t                  in_pixel,
  input  logic                  s1_take,
  output logic                  s1_valid,
  output mlbd_s1_t              s1,
  output logic                  alpha_mode,
  output logic                  even_we,
  output logic                  odd_we,
  output logic [BANK_AW-1:0]    bank_addr,
  output logic                  bank_re
);

  logic [DIMW_W-1:0] width_r;
  logic [DIMH_W-1:0] height_r;
  logic              alpha_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  pix_t              held_r;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  mlbd_s1_t          s1_r;

  logic [DIMW_W-1:0] col_ext;
  logic [DIMW_W-1:0] col_p1;
  logic [DIMH_W-1:0] row_ext;
  logic [DIMH_W-1:0] row_p1;
  logic [DIMW_W-1:0] w_even;
  logic [DIMH_W-1:0] h_even;
  logic              row_end;
  logic              lvl_end;
  logic              w_one;
  logic              h_one;
  logic              two_d;
  logic              produce;
  logic              last;
  logic              hold;

  assign cfg_ready = 1'b1;

  // Sizes are clamped when written: zero acts as one, oversize as the maximum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIMW_W'(MAX_WIDTH);
      height_r <= DIMH_W'(MAX_HEIGHT);
      alpha_r  <= MODE_RGB565;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SRC_WIDTH: begin
          if (cfg_data == '0) begin
            width_r <= DIMW_W'(1);
          end else if (int'(cfg_data) > MAX_WIDTH) begin
            width_r <= DIMW_W'(MAX_WIDTH);
          end else begin
            width_r <= DIMW_W'(cfg_data);
          end
        end
        REG_SRC_HEIGHT: begin
          if (cfg_data == '0) begin
            height_r <= DIMH_W'(1);
          end else if (int'(cfg_data) > MAX_HEIGHT) begin
            height_r <= DIMH_W'(MAX_HEIGHT);
          end else begin
            height_r <= DIMH_W'(cfg_data);
          end
        end
        REG_ALPHA_MODE: alpha_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_ext = DIMW_W'(col_r);
    row_ext = DIMH_W'(row_r);
    col_p1  = col_ext + DIMW_W'(1);
    row_p1  = row_ext + DIMH_W'(1);
    w_even  = {width_r[DIMW_W-1:1], 1'b0};
    h_even  = {height_r[DIMH_W-1:1], 1'b0};
    row_end = (col_p1 >= width_r);
    lvl_end = row_end && (row_p1 >= height_r);
    w_one   = (width_r == DIMW_W'(1));
    h_one   = (height_r == DIMH_W'(1));
    two_d   = !w_one && !h_one;
    produce = 1'b0;
    last    = 1'b0;
    hold    = 1'b0;
    if (w_one && h_one) begin
      produce = 1'b1;
      last    = 1'b1;
    end else if (w_one) begin
      if (!row_r[0]) begin
        hold = 1'b1;
      end else if (row_ext < h_even) begin
        produce = 1'b1;
        last    = (row_p1 == h_even);
      end
    end else if (h_one) begin
      if (!col_r[0]) begin
        hold = 1'b1;
      end else if (col_ext < w_even) begin
        produce = 1'b1;
        last    = (col_p1 == w_even);
      end
    end else if (row_r[0]) begin
      if (!col_r[0]) begin
        hold = 1'b1;
      end else if (col_ext < w_even && row_ext < h_even) begin
        produce = 1'b1;
        last    = (col_p1 == w_even) && (row_p1 == h_even);
      end
    end
  end

  // Even source rows of a two-dimensional level go to the row store, split by column parity.
  assign even_we   = in_xfer && two_d && !row_r[0] && !col_r[0];
  assign odd_we    = in_xfer && two_d && !row_r[0] && col_r[0];
  assign bank_addr = BANK_AW'(col_r >> 1);
  assign bank_re   = in_xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else if (in_xfer) begin
      if (hold) begin
        held_r <= in_pixel;
      end
      if (lvl_end) begin
        col_r <= '0;
        row_r <= '0;
      end else if (row_end) begin
        col_r <= '0;
        row_r <= row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = produce;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // A 1x1 level passes its pixel through, so the pixel also stands in for the
  // held one and the mean of four equal pixels is the pixel itself.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.two_d <= two_d;
      s1_r.last  <= last;
      s1_r.held  <= (w_one && h_one) ? in_pixel : held_r;
      s1_r.px    <= in_pixel;
    end
  end

  assign s1_valid   = s1_valid_r;
  assign s1         = s1_r;
  assign alpha_mode = alpha_r;

endmodule

/* design/mlbd_avg.sv */
// Averaging stage and output register of the mip box downsampler.
module mlbd_avg import mlbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s1_valid,
  input  mlbd_s1_t s1,
  input  pix_t     even_data,
  input  pix_t     odd_data,
  input  logic     alpha_mode,
  output logic     s1_take,
  input  logic     out_stall,
  output logic     out_valid,
  output pix_t     out_pixel_out,
  output logic     out_level_last
);

  logic out_valid_r;
  pix_t pixel_r;
  logic last_r;
  logic out_adv;
  pix_t a_px;
  pix_t b_px;
  pix_t result;

  assign out_adv = !out_valid_r || !out_stall;
  assign s1_take = s1_valid && out_adv;

  // Two-dimensional blocks use the stored row pair; the line cases weight
  // the held pixel and the current pixel twice each.
  always_comb begin
    if (s1.two_d) begin
      a_px = even_data;
      b_px = odd_data;
    end else begin
      a_px = s1.held;
      b_px = s1.held;
    end
    result = avg4(a_px, b_px, s1.held, s1.px, alpha_mode);
    if (!s1.two_d) begin
      result = avg4(a_px, b_px, s1.px, s1.px, alpha_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      pixel_r <= result;
      last_r  <= s1.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = pixel_r;
  assign out_level_last = last_r;

endmodule

/* design/mip_level_box_downsample_16bit.sv */
// Top level of the 2x2 box downsampler that builds the next mip level of a 16-bit texture.
// Source pixels arrive in row-major order, one per cycle at full rate while in_stall is low, and
// the block emits each destination pixel after the source pixel that completes its block has
// passed the registered row store read and then the output register. The rate is set by the
// row store, two banks of MAX_WIDTH/2 entries (even and odd columns) each with one write and
// one registered read port, so both upper pixels of a block are read in the same cycle.
// Stall on the output backs up through the averaging stage to in_stall. Sizes and pixel
// format are written through the cfg port between levels; the row store needs no
// clearing after reset.
module mip_level_box_downsample_16bit import mlbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_pixel_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_pixel_out,
  output logic                  out_level_last
);

  logic               in_xfer;
  logic               s1_valid;
  logic               s1_take;
  mlbd_s1_t           s1;
  logic               alpha_mode;
  logic               even_we;
  logic               odd_we;
  logic [BANK_AW-1:0] bank_addr;
  logic               bank_re;
  pix_t               even_data;
  pix_t               odd_data;

  assign in_stall = s1_valid && !s1_take;
  assign in_xfer  = in_valid && !in_stall;

  mlbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .in_xfer    (in_xfer),
    .in_pixel   (in_pixel_in),
    .s1_take    (s1_take),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .alpha_mode (alpha_mode),
    .even_we    (even_we),
    .odd_we     (odd_we),
    .bank_addr  (bank_addr),
    .bank_re    (bank_re)
  );

  mlbd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (even_we),
    .waddr (bank_addr),
    .wdata (in_pixel_in),
    .re    (bank_re),
    .raddr (bank_addr),
    .rdata (even_data)
  );

  mlbd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (odd_we),
    .waddr (bank_addr),
    .wdata (in_pixel_in),
    .re    (bank_re),
    .raddr (bank_addr),
    .rdata (odd_data)
  );

  mlbd_avg u_avg (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_valid       (s1_valid),
    .s1             (s1),
    .even_data      (even_data),
    .odd_data       (odd_data),
    .alpha_mode     (alpha_mode),
    .s1_take        (s1_take),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_pixel_out  (out_pixel_out),
    .out_level_last (out_level_last)
  );

endmodule
